// ----- src/lagged_fibonacci_random_ranged_defines.svh -----
// Assertion macros for the file that checks its own logic.
`ifndef LAGGED_FIBONACCI_RANDOM_RANGED_DEFINES_SVH
`define LAGGED_FIBONACCI_RANDOM_RANGED_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lfrr_pkg.sv -----
`timescale 1ns / 1ps

package lfrr_pkg;

  localparam int LongLag  = 97;
  localparam int ShortLag = 33;
  localparam int MaxTries = 256;

  localparam int WordW   = 32;
  localparam int OpW     = 2;
  localparam int IndexW  = 7;
  localparam int TableAw = $clog2(LongLag);
  localparam int TriesW  = $clog2(MaxTries);

  localparam int DivSteps = WordW;
  localparam int DivCw    = $clog2(DivSteps);

  localparam int QueueDepth = 2;
  localparam int QueuePw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  localparam logic [OpW-1:0] OpSeed    = 2'd0;
  localparam logic [OpW-1:0] OpRaw     = 2'd1;
  localparam logic [OpW-1:0] OpBounded = 2'd2;

  typedef enum logic [1:0] {
    CmdSeed,
    CmdRaw,
    CmdBounded
  } cmd_kind_e;

  // The value field carries the seed word or the limit of a bounded draw.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [TableAw-1:0] index;
    logic [WordW-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/lfrr_front.sv -----
`timescale 1ns / 1ps

module lfrr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lfrr_pkg::OpW-1:0]       op_i,
  input  logic [lfrr_pkg::IndexW-1:0]    seed_index_i,
  input  logic [lfrr_pkg::WordW-1:0]     seed_value_i,
  input  logic [lfrr_pkg::WordW-1:0]     limit_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_pop_i,
  output lfrr_pkg::cmd_t                 cmd_o
);
  import lfrr_pkg::*;

  cmd_t               slot_q [QueueDepth];
  logic [QueuePw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCw-1:0] count_q, count_d;

  cmd_t cmd_in;
  logic keep;
  logic push;

  // Unused op codes and seed loads outside the table are dropped here.
  always_comb begin
    cmd_in.index = TableAw'(seed_index_i);
    cmd_in.value = seed_value_i;
    cmd_in.kind  = CmdSeed;
    keep         = 1'b0;
    case (op_i)
      OpSeed: begin
        keep = (seed_index_i < IndexW'(LongLag));
      end
      OpRaw: begin
        cmd_in.kind = CmdRaw;
        keep        = 1'b1;
      end
      OpBounded: begin
        cmd_in.kind  = CmdBounded;
        cmd_in.value = limit_i;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o  = (count_q == QueueCw'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = QueuePw'(wr_ptr_q + 1'b1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = QueuePw'(rd_ptr_q + 1'b1);
    end
    if (push && !cmd_pop_i) begin
      count_d = QueueCw'(count_q + 1'b1);
    end else if (!push && cmd_pop_i) begin
      count_d = QueueCw'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- src/lfrr_div.sv -----
`timescale 1ns / 1ps

module lfrr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfrr_pkg::div_req_t  req_i,
  output lfrr_pkg::div_rsp_t  rsp_o
);
  import lfrr_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCw-1:0]    cnt_q, cnt_d;
  logic [WordW-1:0]    rem_q, rem_d;
  logic [WordW-1:0]    dvd_q, dvd_d;
  logic [WordW-1:0]    dsr_q, dsr_d;

  logic [WordW:0]      rem_sh;
  logic [WordW:0]      diff;

  // Restoring remainder, one dividend bit per cycle.
  assign rem_sh = {rem_q, dvd_q[WordW-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = diff[WordW] ? rem_sh[WordW-1:0] : diff[WordW-1:0];
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      cnt_d = DivCw'(cnt_q + 1'b1);
      if (cnt_q == DivCw'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- src/lfrr_back.sv -----
`timescale 1ns / 1ps

module lfrr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lfrr_pkg::WordW-1:0]   range_top_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  lfrr_pkg::cmd_t               cmd_i,
  output lfrr_pkg::div_req_t           div_req_o,
  input  lfrr_pkg::div_rsp_t           div_rsp_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lfrr_pkg::WordW-1:0]   number_o
);
  import lfrr_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StThr  = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StMod  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [TableAw-1:0] lp_q, lp_d;
  logic [TableAw-1:0] sp_q, sp_d;
  logic               out_valid_q, out_valid_d;
  logic [LongLag-1:0] valid_q;
  logic               ok_l_q, ok_s_q;

  cmd_kind_e          kind_q, kind_d;
  logic [WordW-1:0]   limit_q, limit_d;
  logic [WordW-1:0]   thr_q, thr_d;
  logic [TriesW-1:0]  tries_q, tries_d;
  logic [WordW-1:0]   out_q, out_d;

  logic [WordW-1:0]   mem_q [LongLag];
  logic [WordW-1:0]   raw_l_q, raw_s_q;

  logic               we;
  logic [TableAw-1:0] waddr;
  logic [WordW-1:0]   wdata;
  logic [WordW-1:0]   word_l, word_s, sum;

  function automatic logic [TableAw-1:0] step_back(input logic [TableAw-1:0] pos);
    step_back = (pos == '0) ? TableAw'(LongLag - 1) : TableAw'(pos - 1'b1);
  endfunction

  // Entries never written read as zero.
  assign word_l = ok_l_q ? raw_l_q : '0;
  assign word_s = ok_s_q ? raw_s_q : '0;
  assign sum    = word_l + word_s;

  always_comb begin
    state_d     = state_q;
    lp_d        = lp_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    limit_d     = limit_q;
    thr_d       = thr_q;
    tries_d     = tries_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = lp_q;
    wdata       = sum;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = sum;
    div_req_o.divisor  = limit_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          kind_d    = cmd_i.kind;
          limit_d   = cmd_i.value;
          tries_d   = '0;
          case (cmd_i.kind)
            CmdSeed: begin
              we    = 1'b1;
              waddr = cmd_i.index;
              wdata = cmd_i.value;
            end
            CmdRaw: begin
              state_d = StRead;
            end
            CmdBounded: begin
              if (cmd_i.value == '0) begin
                out_valid_d = 1'b1;
                out_d       = '0;
              end else begin
                div_req_o.start    = 1'b1;
                div_req_o.dividend = range_top_i;
                div_req_o.divisor  = cmd_i.value;
                state_d            = StThr;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StThr: begin
        if (div_rsp_i.done) begin
          thr_d   = range_top_i - div_rsp_i.rem;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StAdd;
      end
      StAdd: begin
        we      = 1'b1;
        lp_d    = step_back(lp_q);
        sp_d    = step_back(sp_q);
        tries_d = TriesW'(tries_q + 1'b1);
        if (kind_q == CmdRaw) begin
          out_valid_d = 1'b1;
          out_d       = sum;
          state_d     = StIdle;
        end else if (thr_q == '0 || sum < thr_q || tries_q == TriesW'(MaxTries - 1)) begin
          div_req_o.start = 1'b1;
          state_d         = StMod;
        end else begin
          state_d = StRead;
        end
      end
      StMod: begin
        if (div_rsp_i.done) begin
          out_valid_d = 1'b1;
          out_d       = div_rsp_i.rem;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lp_q        <= TableAw'(LongLag - 1);
      sp_q        <= TableAw'(ShortLag - 1);
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      ok_l_q      <= 1'b0;
      ok_s_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      lp_q        <= lp_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      ok_l_q      <= valid_q[lp_q];
      ok_s_q      <= valid_q[sp_q];
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    limit_q <= limit_d;
    thr_q   <= thr_d;
    tries_q <= tries_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    raw_l_q <= mem_q[lp_q];
    raw_s_q <= mem_q[sp_q];
  end

  assign out_valid_o = out_valid_q;
  assign number_o    = out_q;

endmodule

// ----- src/lagged_fibonacci_random_ranged.sv -----
`timescale 1ns / 1ps
// A raw draw passes the read and add states once at the head of the queue; a seed load is
// written as it is popped, and a new command is taken only once the result has been transferred.
// A bounded draw with a zero limit gives zero; otherwise its draws pass the read and add
// states between two passes of the one-bit-per-cycle remainder unit.
// Reset is asynchronous and active low: table entries read as zero until written, the
// positions return to 96 and 32, and the range ceiling returns to all ones.

`include "lagged_fibonacci_random_ranged_defines.svh"

module lagged_fibonacci_random_ranged (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfrr_pkg::WordW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lfrr_pkg::OpW-1:0]     op_i,
  input  logic [lfrr_pkg::IndexW-1:0]  seed_index_i,
  input  logic [lfrr_pkg::WordW-1:0]   seed_value_i,
  input  logic [lfrr_pkg::WordW-1:0]   limit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lfrr_pkg::WordW-1:0]   number_o
);
  import lfrr_pkg::*;

  logic [WordW-1:0] range_top_q;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             draw_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_top_q <= '1;
    end else if (cfg_we_i) begin
      range_top_q <= cfg_data_i;
    end
  end

  lfrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .seed_index_i (seed_index_i),
    .seed_value_i (seed_value_i),
    .limit_i      (limit_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  lfrr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lfrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .range_top_i  (range_top_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .number_o     (number_o)
  );

  assign draw_in = in_valid_i && !in_stall_o && (op_i == OpRaw || op_i == OpBounded);

  `LFRR_ASSERT_NEXT(a_push_lands, draw_in, cmd_valid, "accepted draw did not reach the queue")
  `LFRR_ASSERT_SAME(a_pop_needs_room, cmd_pop, cmd_valid && !out_valid_o, "bad command pop")
  `LFRR_ASSERT_NEXT(a_div_single_start, div_req.start, !div_req.start, "remainder unit restarted")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lfrr_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int HoldOffCycles = 400;
  localparam int SettleCycles  = 100;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] idx;
    logic [WordW-1:0]  val;
    logic [WordW-1:0]  lim;
  } lfg_item_t;

  class lfg_scoreboard;
    logic [WordW-1:0] lag_words [LongLag];
    int unsigned      long_pos;
    int unsigned      short_pos;
    logic [WordW-1:0] range_top;
    logic [WordW-1:0] expected_numbers [$];
    int               errors;

    function new();
      foreach (lag_words[i]) lag_words[i] = '0;
      long_pos   = LongLag - 1;
      short_pos  = ShortLag - 1;
      range_top  = '1;
      errors     = 0;
    endfunction

    function logic [WordW-1:0] next_word();
      logic [WordW-1:0] w;
      w = lag_words[long_pos] + lag_words[short_pos];
      lag_words[long_pos] = w;
      long_pos  = (long_pos == 0) ? LongLag - 1 : long_pos - 1;
      short_pos = (short_pos == 0) ? LongLag - 1 : short_pos - 1;
      return w;
    endfunction

    function logic [WordW-1:0] bounded_word(logic [WordW-1:0] lim);
      logic [WordW-1:0] threshold;
      logic [WordW-1:0] w;
      int               tries;
      if (lim == '0) return '0;
      threshold = range_top - (range_top % lim);
      w = next_word();
      if (threshold == '0) return w % lim;
      tries = 1;
      while (w >= threshold && tries < MaxTries) begin
        w = next_word();
        tries++;
      end
      return w % lim;
    endfunction

    function void note_input(lfg_item_t it);
      case (it.op)
        OpSeed: begin
          if (it.idx < LongLag) lag_words[it.idx] = it.val;
        end
        OpRaw: expected_numbers.push_back(next_word());
        OpBounded: expected_numbers.push_back(bounded_word(it.lim));
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [WordW-1:0] got);
      logic [WordW-1:0] want;
      if (expected_numbers.size() == 0) begin
        report($sformatf("number 0x%08h arrived with nothing expected", got));
      end else begin
        want = expected_numbers.pop_front();
        if (got !== want) begin
          report($sformatf("number 0x%08h, expected 0x%08h", got, want));
        end
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [WordW-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OpW-1:0]    op = '0;
  logic [IndexW-1:0] seed_index = '0;
  logic [WordW-1:0]  seed_value = '0;
  logic [WordW-1:0]  limit = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WordW-1:0]  number;

  lfg_scoreboard sb = new();
  int rx_stall_pct = 0;
  int hold_left = 0;

  always #4 clk = ~clk;

  lagged_fibonacci_random_ranged dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .seed_index_i (seed_index),
    .seed_value_i (seed_value),
    .limit_i      (limit),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .number_o     (number)
  );

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(number);
  end

  function automatic logic [WordW-1:0] pick_limit();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'd1;
      2: return $urandom_range(16, 2);
      3: return $urandom_range(1000, 17);
      4, 5: return $urandom;
      6: return 32'd1 << $urandom_range(31);
      7: return 32'hFFFF_FFFF - $urandom_range(3);
      8: return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(65535, 2);
    endcase
  endfunction

  function automatic lfg_item_t random_item();
    lfg_item_t it;
    int        r;
    r = $urandom_range(99);
    it.idx = IndexW'($urandom_range(127));
    it.val = $urandom;
    it.lim = $urandom;
    if (r < 25) begin
      it.op = OpSeed;
      if ($urandom_range(9) != 0) it.idx = IndexW'($urandom_range(LongLag - 1));
    end else if (r < 55) begin
      it.op = OpRaw;
    end else if (r < 95) begin
      it.op = OpBounded;
      it.lim = pick_limit();
    end else begin
      it.op = OpUnused;
    end
    return it;
  endfunction

  task automatic send_item(lfg_item_t it);
    @(negedge clk);
    in_valid   <= 1'b1;
    op         <= it.op;
    seed_index <= it.idx;
    seed_value <= it.val;
    limit      <= it.lim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_fields(logic [OpW-1:0] o, logic [IndexW-1:0] i,
                             logic [WordW-1:0] v, logic [WordW-1:0] l);
    lfg_item_t it;
    it.op  = o;
    it.idx = i;
    it.val = v;
    it.lim = l;
    send_item(it);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    idle_cycle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_range_top(logic [WordW-1:0] v);
    drain_results();
    repeat (SettleCycles) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    sb.range_top = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reseed_table();
    for (int i = 0; i < LongLag; i++) send_fields(OpSeed, IndexW'(i), $urandom, $urandom);
  endtask

  task automatic run_random(int count, int tx_pct, int rx_pct, int hold_at, int pause_at);
    rx_stall_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < tx_pct) idle_cycle();
      send_item(random_item());
      if (i == hold_at) hold_left = HoldOffCycles;
      if (i == pause_at) drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Draws from the unseeded table, a zero limit and the seed index edges.
    send_fields(OpRaw, IndexW'($urandom), $urandom, $urandom);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'd0);
    send_fields(OpSeed, 7'd0, 32'hFFFF_FFFF, $urandom);
    send_fields(OpSeed, 7'd96, 32'h1234_5678, $urandom);
    send_fields(OpSeed, 7'd32, 32'hFFFF_FFFF, $urandom);
    send_fields(OpSeed, 7'd127, 32'hDEAD_BEEF, $urandom);
    send_fields(OpSeed, 7'd97, 32'h0000_0001, $urandom);
    send_fields(OpUnused, IndexW'($urandom), $urandom, $urandom);
    send_fields(OpRaw, 7'd0, 32'd0, 32'd0);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'd1);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'hFFFF_FFFF);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'h8000_0001);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'h8000_0000);
    send_fields(OpSeed, 7'd95, 32'hFFFF_FFFF, $urandom);
    send_fields(OpSeed, 7'd31, 32'hFFFF_FFFF, $urandom);
    send_fields(OpBounded, 7'h7F, 32'hFFFF_FFFF, 32'd7);
    send_fields(OpRaw, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(OpRaw, IndexW'($urandom), $urandom, $urandom);
    send_fields(OpUnused, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(OpRaw, IndexW'($urandom), $urandom, $urandom);

    reseed_table();
    run_random(330, 0, 0, 100, 200);

    // With a ceiling of one, any limit above one gives a zero threshold and takes
    // the first word, and a limit of one rejects every word except zero.
    write_range_top(32'd1);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'd1);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'd2);
    send_fields(OpBounded, IndexW'($urandom), $urandom, 32'hFFFF_FFFF);
    run_random(60, 63, 0, -1, -1);

    write_range_top(32'hC000_0000);
    reseed_table();
    run_random(250, 0, 63, 50, -1);

    write_range_top(32'hFFFF_FFFF);
    run_random(250, 15, 15, -1, 120);

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lagged_fibonacci_random_ranged verification clean");
    end else begin
      $display("lagged_fibonacci_random_ranged verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("lagged_fibonacci_random_ranged verification failed");
    $finish;
  end

endmodule
